FILE: rtl/gga_pkg.sv
// Shared constants, types and widths for the NMEA GGA coordinate extractor.
`timescale 1ns / 1ps

package gga_pkg;

    // Characters and the sentence tag.
    localparam logic [7:0]  CHAR_DOLLAR = 8'h24;
    localparam logic [7:0]  CHAR_COMMA  = 8'h2C;
    localparam logic [7:0]  CHAR_ZERO   = 8'h30;
    localparam logic [7:0]  CHAR_NINE   = 8'h39;
    localparam logic [23:0] TAG_GGA     = 24'h474741;

    // Field numbers counted by commas after the tag.
    localparam logic [2:0] FIELD_LAT = 3'd2;
    localparam logic [2:0] FIELD_LON = 3'd4;
    localparam logic [2:0] FIELD_END = 3'd5;
    localparam logic [2:0] FIELD_MAX = 3'd7;

    // Character positions of the two coordinate fields.
    localparam logic [3:0] LAT_POSITIONS = 4'd10;
    localparam logic [3:0] LAT_DOT       = 4'd4;
    localparam logic [3:0] LON_POSITIONS = 4'd11;
    localparam logic [3:0] LON_DOT       = 4'd5;

    // Accumulator and result widths.
    localparam int unsigned LAT_ACC_W  = 30;
    localparam int unsigned LON_ACC_W  = 34;
    localparam int unsigned ACC_W      = 34;
    localparam int unsigned PAD_W      = 4;
    localparam int unsigned DEG_W      = 10;
    localparam int unsigned MIN_W      = 24;
    localparam int unsigned QUO_W      = 18;
    localparam int unsigned FRAC_W     = 17;
    localparam int unsigned LAT_DEG_W  = 7;

    // Conversion constants.
    localparam int unsigned DEG_SCALE    = 10000000;
    localparam int unsigned MIN_DIVISOR  = 60;
    localparam int unsigned FRACTION_MAX = 99999;

    // Reciprocals for the two constant divisions. Degrees are the padded value shifted
    // down by seven, times DEG_RECIP, over 2^44; the fraction is the minutes times
    // MIN_RECIP over 2^30. Both are exact for every value a decimal field can hold.
    localparam int unsigned DEG_PRE_SHIFT   = 7;
    localparam int unsigned DEG_RECIP_SHIFT = 44;
    localparam logic [27:0] DEG_RECIP       = 28'd225179982;
    localparam int unsigned MIN_RECIP_SHIFT = 30;
    localparam logic [24:0] MIN_RECIP       = 25'd17895698;

    // Depth of the queue between parser and converter.
    localparam int unsigned QUEUE_DEPTH = 2;

    // One closed sentence: raw digits plus the number of zero digits to append.
    typedef struct packed {
        logic [LAT_ACC_W-1:0] lat_acc;
        logic [PAD_W-1:0]     lat_pad;
        logic [LON_ACC_W-1:0] lon_acc;
        logic [PAD_W-1:0]     lon_pad;
    } item_t;

endpackage

FILE: rtl/nmea_gga_coordinate_extractor.sv
// The parser accepts one received character every cycle while the sentence queue has room.
// Each comma that closes the longitude field of a GGA sentence places the raw digits in
// a queue (default two entries). A converter back end then appends the missing zero digits
// (one per cycle, up to ten), and then splits off whole degrees, forms the minutes and
// divides them by sixty in states of their own, the divisions being reciprocal products.
// The back end takes a new entry from the queue only after the previous position has been
// loaded into the output register; short or empty fields take longer, as they need more
// padding. The latitude and longitude converters run side by side. The input stalls only
// when the queue is full, which needs several very short sentences in a row or an output
// that is held off.
`timescale 1ns / 1ps

module nmea_gga_coordinate_extractor
#(
    parameter int unsigned QUEUE_DEPTH = gga_pkg::QUEUE_DEPTH
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [7:0]                      rx_byte,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [gga_pkg::LAT_DEG_W-1:0]   lat_degrees,
    output logic [gga_pkg::FRAC_W-1:0]      lat_fraction,
    output logic [gga_pkg::DEG_W-1:0]       lon_degrees,
    output logic [gga_pkg::FRAC_W-1:0]      lon_fraction
);

    logic               queue_full;
    logic               push;
    gga_pkg::item_t     push_item;
    logic               pop;
    logic               queue_not_empty;
    gga_pkg::item_t     pop_item;

    gga_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .queue_full (queue_full),
        .push       (push),
        .push_item  (push_item)
    );

    gga_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .pop       (pop),
        .not_empty (queue_not_empty),
        .pop_item  (pop_item)
    );

    gga_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (queue_not_empty),
        .item         (pop_item),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .lat_degrees  (lat_degrees),
        .lat_fraction (lat_fraction),
        .lon_degrees  (lon_degrees),
        .lon_fraction (lon_fraction)
    );

endmodule

FILE: rtl/gga_front.sv
// Byte parser: tag detection, field counting and digit accumulation.
`timescale 1ns / 1ps

module gga_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          rx_byte,
    input  logic                queue_full,
    output logic                push,
    output gga_pkg::item_t      push_item
);

    logic [23:0]                     tag_window_reg, tag_window_next;
    logic                            in_gga_reg, in_gga_next;
    logic [2:0]                      field_count_reg, field_count_next;
    logic [gga_pkg::LAT_ACC_W-1:0]   lat_acc_reg, lat_acc_next;
    logic [3:0]                      lat_idx_reg, lat_idx_next;
    logic [gga_pkg::LON_ACC_W-1:0]   lon_acc_reg, lon_acc_next;
    logic [3:0]                      lon_idx_reg, lon_idx_next;
    logic [23:0]                     window_shifted;
    logic [3:0]                      digit;
    logic [3:0]                      lat_digits;
    logic [3:0]                      lon_digits;
    logic                            accept;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;

    assign digit = (rx_byte >= gga_pkg::CHAR_ZERO && rx_byte <= gga_pkg::CHAR_NINE)
                   ? 4'(rx_byte - gga_pkg::CHAR_ZERO) : 4'd0;

    assign window_shifted = {tag_window_reg[15:0], rx_byte};

    // The dot position is counted as a position but carries no digit.
    assign lat_digits = lat_idx_reg - ((lat_idx_reg > gga_pkg::LAT_DOT) ? 4'd1 : 4'd0);
    assign lon_digits = lon_idx_reg - ((lon_idx_reg > gga_pkg::LON_DOT) ? 4'd1 : 4'd0);

    assign push_item.lat_acc = lat_acc_reg;
    assign push_item.lat_pad = gga_pkg::LAT_POSITIONS - 4'd1 - lat_digits;
    assign push_item.lon_acc = lon_acc_reg;
    assign push_item.lon_pad = gga_pkg::LON_POSITIONS - 4'd1 - lon_digits;

    always_comb
    begin
        tag_window_next  = tag_window_reg;
        in_gga_next      = in_gga_reg;
        field_count_next = field_count_reg;
        lat_acc_next     = lat_acc_reg;
        lat_idx_next     = lat_idx_reg;
        lon_acc_next     = lon_acc_reg;
        lon_idx_next     = lon_idx_reg;
        push             = 1'b0;
        if (accept)
        begin
            priority if (rx_byte == gga_pkg::CHAR_DOLLAR)
            begin
                in_gga_next      = 1'b0;
                field_count_next = 3'd0;
                lat_acc_next     = '0;
                lat_idx_next     = 4'd0;
                lon_acc_next     = '0;
                lon_idx_next     = 4'd0;
            end
            else if (!in_gga_reg)
            begin
                if (window_shifted == gga_pkg::TAG_GGA)
                begin
                    in_gga_next     = 1'b1;
                    tag_window_next = 24'd0;
                end
                else
                begin
                    tag_window_next = window_shifted;
                end
            end
            else if (rx_byte == gga_pkg::CHAR_COMMA)
            begin
                if (field_count_reg == gga_pkg::FIELD_LON)
                begin
                    field_count_next = gga_pkg::FIELD_END;
                    push             = 1'b1;
                end
                else if (field_count_reg != gga_pkg::FIELD_MAX)
                begin
                    field_count_next = field_count_reg + 3'd1;
                end
            end
            else if (field_count_reg == gga_pkg::FIELD_LAT
                     && lat_idx_reg < gga_pkg::LAT_POSITIONS)
            begin
                if (lat_idx_reg != gga_pkg::LAT_DOT)
                begin
                    lat_acc_next = gga_pkg::LAT_ACC_W'({lat_acc_reg, 3'b000}
                                   + {lat_acc_reg, 1'b0} + {26'd0, digit});
                end
                lat_idx_next = lat_idx_reg + 4'd1;
            end
            else if (field_count_reg == gga_pkg::FIELD_LON
                     && lon_idx_reg < gga_pkg::LON_POSITIONS)
            begin
                if (lon_idx_reg != gga_pkg::LON_DOT)
                begin
                    lon_acc_next = gga_pkg::LON_ACC_W'({lon_acc_reg, 3'b000}
                                   + {lon_acc_reg, 1'b0} + {30'd0, digit});
                end
                lon_idx_next = lon_idx_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_window_reg  <= 24'd0;
            in_gga_reg      <= 1'b0;
            field_count_reg <= 3'd0;
            lat_acc_reg     <= '0;
            lat_idx_reg     <= 4'd0;
            lon_acc_reg     <= '0;
            lon_idx_reg     <= 4'd0;
        end
        else
        begin
            tag_window_reg  <= tag_window_next;
            in_gga_reg      <= in_gga_next;
            field_count_reg <= field_count_next;
            lat_acc_reg     <= lat_acc_next;
            lat_idx_reg     <= lat_idx_next;
            lon_acc_reg     <= lon_acc_next;
            lon_idx_reg     <= lon_idx_next;
        end
    end

endmodule

FILE: rtl/gga_queue.sv
// Small register queue that carries closed sentences from parser to converter.
`timescale 1ns / 1ps

module gga_queue
#(
    parameter int unsigned DEPTH = gga_pkg::QUEUE_DEPTH
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  gga_pkg::item_t  push_item,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output gga_pkg::item_t  pop_item
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    gga_pkg::item_t     entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_item  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: rtl/gga_cvt.sv
// Converter: zero padding, then degree split and minutes-to-fraction by reciprocal products.
`timescale 1ns / 1ps

module gga_cvt
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [gga_pkg::ACC_W-1:0]       acc,
    input  logic [gga_pkg::PAD_W-1:0]       pad,
    output logic                            done,
    output logic [gga_pkg::DEG_W-1:0]       degrees,
    output logic [gga_pkg::FRAC_W-1:0]      fraction
);

    localparam int unsigned DEG_PROD_W = gga_pkg::ACC_W - gga_pkg::DEG_PRE_SHIFT
                                         + $bits(gga_pkg::DEG_RECIP);
    localparam int unsigned FRAC_PROD_W = gga_pkg::MIN_W + $bits(gga_pkg::MIN_RECIP);

    typedef enum logic [5:0]
    {
        CV_IDLE = 6'b000001,
        CV_PAD  = 6'b000010,
        CV_DEG  = 6'b000100,
        CV_MIN  = 6'b001000,
        CV_FRAC = 6'b010000,
        CV_DONE = 6'b100000
    } cvt_state_t;

    cvt_state_t                     state_reg, state_next;
    logic [gga_pkg::ACC_W-1:0]      val_reg, val_next;
    logic [gga_pkg::PAD_W-1:0]      cnt_reg, cnt_next;
    logic [gga_pkg::DEG_W-1:0]      deg_reg, deg_next;
    logic [gga_pkg::QUO_W-1:0]      quo_reg, quo_next;
    logic [DEG_PROD_W-1:0]          deg_prod;
    logic [FRAC_PROD_W-1:0]         frac_prod;

    // Dividing by 128 first leaves a 27-bit value, small enough for the reciprocal of 78125.
    assign deg_prod  = DEG_PROD_W'(val_reg[gga_pkg::ACC_W-1:gga_pkg::DEG_PRE_SHIFT])
                       * DEG_PROD_W'(gga_pkg::DEG_RECIP);
    assign frac_prod = FRAC_PROD_W'(val_reg[gga_pkg::MIN_W-1:0])
                       * FRAC_PROD_W'(gga_pkg::MIN_RECIP);

    assign done     = (state_reg == CV_DONE);
    assign degrees  = deg_reg;
    assign fraction = (quo_reg > gga_pkg::QUO_W'(gga_pkg::FRACTION_MAX))
                      ? gga_pkg::FRAC_W'(gga_pkg::FRACTION_MAX)
                      : quo_reg[gga_pkg::FRAC_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        val_next   = val_reg;
        cnt_next   = cnt_reg;
        deg_next   = deg_reg;
        quo_next   = quo_reg;
        unique case (state_reg)
            CV_IDLE, CV_DONE:
            begin
                if (start)
                begin
                    val_next   = acc;
                    cnt_next   = pad;
                    deg_next   = '0;
                    quo_next   = '0;
                    state_next = CV_PAD;
                end
            end
            CV_PAD:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = CV_DEG;
                end
                else
                begin
                    val_next = gga_pkg::ACC_W'({val_reg, 3'b000} + {val_reg, 1'b0});
                    cnt_next = cnt_reg - gga_pkg::PAD_W'(1);
                end
            end
            CV_DEG:
            begin
                deg_next   = deg_prod[gga_pkg::DEG_RECIP_SHIFT +: gga_pkg::DEG_W];
                state_next = CV_MIN;
            end
            CV_MIN:
            begin
                // What is left after the whole degrees are the minutes, below 10^7.
                val_next   = val_reg - gga_pkg::ACC_W'(deg_reg)
                             * gga_pkg::ACC_W'(gga_pkg::DEG_SCALE);
                state_next = CV_FRAC;
            end
            CV_FRAC:
            begin
                quo_next   = frac_prod[gga_pkg::MIN_RECIP_SHIFT +: gga_pkg::QUO_W];
                state_next = CV_DONE;
            end
            default:
            begin
                state_next = CV_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CV_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        deg_reg <= deg_next;
        quo_reg <= quo_next;
    end

endmodule

FILE: rtl/gga_back.sv
// Back end: takes queued sentences, runs both converters and holds the result beat.
`timescale 1ns / 1ps

module gga_back
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    input  gga_pkg::item_t                  item,
    output logic                            pop,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [gga_pkg::LAT_DEG_W-1:0]   lat_degrees,
    output logic [gga_pkg::FRAC_W-1:0]      lat_fraction,
    output logic [gga_pkg::DEG_W-1:0]       lon_degrees,
    output logic [gga_pkg::FRAC_W-1:0]      lon_fraction
);

    typedef enum logic [1:0]
    {
        BK_IDLE = 2'b01,
        BK_RUN  = 2'b10
    } back_state_t;

    back_state_t                        state_reg, state_next;
    logic                               out_valid_reg, out_valid_next;
    logic                               load;
    logic                               start;
    logic                               lat_done, lon_done;
    logic [gga_pkg::DEG_W-1:0]          lat_deg_full, lon_deg;
    logic [gga_pkg::FRAC_W-1:0]         lat_frac, lon_frac;
    logic [gga_pkg::LAT_DEG_W-1:0]      lat_deg_reg;
    logic [gga_pkg::FRAC_W-1:0]         lat_frac_reg;
    logic [gga_pkg::DEG_W-1:0]          lon_deg_reg;
    logic [gga_pkg::FRAC_W-1:0]         lon_frac_reg;

    gga_cvt u_lat_cvt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .acc      ({4'd0, item.lat_acc}),
        .pad      (item.lat_pad),
        .done     (lat_done),
        .degrees  (lat_deg_full),
        .fraction (lat_frac)
    );

    gga_cvt u_lon_cvt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .acc      (item.lon_acc),
        .pad      (item.lon_pad),
        .done     (lon_done),
        .degrees  (lon_deg),
        .fraction (lon_frac)
    );

    assign out_valid    = out_valid_reg;
    assign lat_degrees  = lat_deg_reg;
    assign lat_fraction = lat_frac_reg;
    assign lon_degrees  = lon_deg_reg;
    assign lon_fraction = lon_frac_reg;
    assign pop          = start;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        start          = 1'b0;
        load           = 1'b0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            BK_IDLE:
            begin
                if (item_valid)
                begin
                    start      = 1'b1;
                    state_next = BK_RUN;
                end
            end
            BK_RUN:
            begin
                // The result register must be free before a new beat is loaded.
                if (lat_done && lon_done && (!out_valid_reg || out_ready))
                begin
                    load           = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            lat_deg_reg  <= lat_deg_full[gga_pkg::LAT_DEG_W-1:0];
            lat_frac_reg <= lat_frac;
            lon_deg_reg  <= lon_deg;
            lon_frac_reg <= lon_frac;
        end
    end

endmodule

FILE: tb/sv/gga_position_checker.sv
// Checker for the GGA coordinate extractor: predicts each position from the received beats.
`timescale 1ns / 1ps

module gga_position_checker
    import gga_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic [7:0]           rx_byte,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic [LAT_DEG_W-1:0] lat_degrees,
    input  logic [FRAC_W-1:0]    lat_fraction,
    input  logic [DEG_W-1:0]     lon_degrees,
    input  logic [FRAC_W-1:0]    lon_fraction,
    output int                   errors,
    output int                   pending
);

    typedef struct packed {
        logic [LAT_DEG_W-1:0] lat_degrees;
        logic [FRAC_W-1:0]    lat_fraction;
        logic [DEG_W-1:0]     lon_degrees;
        logic [FRAC_W-1:0]    lon_fraction;
    } position_t;

    position_t            expected_positions[$];
    logic [23:0]          tag_window;
    logic                 in_sentence;
    logic [2:0]           field_no;
    logic [LAT_ACC_W-1:0] lat_digits;
    logic [3:0]           lat_taken;
    logic [LON_ACC_W-1:0] lon_digits;
    logic [3:0]           lon_taken;
    int                   mismatch_count;

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("%0t ns: mismatch: %s", $time, what);
    endtask

    function automatic logic [3:0] char_digit(input logic [7:0] ch);
        if (ch >= CHAR_ZERO && ch <= CHAR_NINE)
            return 4'(ch - CHAR_ZERO);
        return 4'd0;
    endfunction

    // Missing positions become trailing zeros before degrees and minutes are split.
    function automatic void split_degrees(input logic [63:0] digits, input logic [3:0] taken,
                                          input logic [3:0] positions, input logic [3:0] dot,
                                          output logic [63:0] whole,
                                          output logic [63:0] fraction);
        logic [63:0] scaled;
        int unsigned count;
        int unsigned k;
        scaled = digits;
        count = (taken > dot) ? taken - 4'd1 : taken;
        for (k = count; k < positions - 1; k++)
            scaled = scaled * 64'd10;
        whole = scaled / DEG_SCALE;
        fraction = (scaled - whole * DEG_SCALE) / MIN_DIVISOR;
        if (fraction > FRACTION_MAX)
            fraction = FRACTION_MAX;
    endfunction

    task automatic take_char(input logic [7:0] ch);
        position_t   fix;
        logic [63:0] whole;
        logic [63:0] fraction;
        if (ch == CHAR_DOLLAR)
        begin
            // The tag window keeps its contents across a dollar sign.
            in_sentence = 1'b0;
            field_no = 3'd0;
            lat_digits = '0;
            lat_taken = 4'd0;
            lon_digits = '0;
            lon_taken = 4'd0;
        end
        else if (!in_sentence)
        begin
            tag_window = {tag_window[15:0], ch};
            if (tag_window == TAG_GGA)
            begin
                in_sentence = 1'b1;
                tag_window = 24'd0;
            end
        end
        else if (ch == CHAR_COMMA)
        begin
            if (field_no == FIELD_LON)
            begin
                field_no = FIELD_END;
                split_degrees(64'(lat_digits), lat_taken, LAT_POSITIONS, LAT_DOT,
                              whole, fraction);
                fix.lat_degrees = whole[LAT_DEG_W-1:0];
                fix.lat_fraction = fraction[FRAC_W-1:0];
                split_degrees(64'(lon_digits), lon_taken, LON_POSITIONS, LON_DOT,
                              whole, fraction);
                fix.lon_degrees = whole[DEG_W-1:0];
                fix.lon_fraction = fraction[FRAC_W-1:0];
                expected_positions.push_back(fix);
            end
            else if (field_no < FIELD_MAX)
                field_no = field_no + 3'd1;
        end
        else if (field_no == FIELD_LAT && lat_taken < LAT_POSITIONS)
        begin
            if (lat_taken != LAT_DOT)
                lat_digits = lat_digits * 30'd10 + 30'(char_digit(ch));
            lat_taken = lat_taken + 4'd1;
        end
        else if (field_no == FIELD_LON && lon_taken < LON_POSITIONS)
        begin
            if (lon_taken != LON_DOT)
                lon_digits = lon_digits * 34'd10 + 34'(char_digit(ch));
            lon_taken = lon_taken + 4'd1;
        end
    endtask

    task automatic check_position();
        position_t want;
        if (expected_positions.size() == 0)
        begin
            report_mismatch($sformatf("position %0d %0d / %0d %0d with none expected",
                                      lat_degrees, lat_fraction, lon_degrees, lon_fraction));
        end
        else
        begin
            want = expected_positions.pop_front();
            if (lat_degrees !== want.lat_degrees)
                report_mismatch($sformatf("lat_degrees %0d, expected %0d",
                                          lat_degrees, want.lat_degrees));
            if (lat_fraction !== want.lat_fraction)
                report_mismatch($sformatf("lat_fraction %0d, expected %0d",
                                          lat_fraction, want.lat_fraction));
            if (lon_degrees !== want.lon_degrees)
                report_mismatch($sformatf("lon_degrees %0d, expected %0d",
                                          lon_degrees, want.lon_degrees));
            if (lon_fraction !== want.lon_fraction)
                report_mismatch($sformatf("lon_fraction %0d, expected %0d",
                                          lon_fraction, want.lon_fraction));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_positions.delete();
            tag_window = 24'd0;
            in_sentence = 1'b0;
            field_no = 3'd0;
            lat_digits = '0;
            lat_taken = 4'd0;
            lon_digits = '0;
            lon_taken = 4'd0;
            mismatch_count = 0;
            errors <= 0;
            pending <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                take_char(rx_byte);
            if (out_valid && out_ready)
                check_position();
            errors <= mismatch_count;
            pending <= expected_positions.size();
        end
    end

endmodule

FILE: tb/sv/nmea_gga_coordinate_extractor_test.sv
// Top of the GGA coordinate extractor test: clock, reset, sentence stimulus and verdict.
`timescale 1ns / 1ps

module nmea_gga_coordinate_extractor_test;
    import gga_pkg::*;

    localparam int TOTAL_CHARS   = 1950;
    localparam int CALM_CHARS    = 250;
    localparam int HOLD_CYCLES   = 400;
    localparam int FILL_COUNT    = 24;
    localparam int STALL_LIMIT   = 3000;
    localparam int DRAIN_CYCLES  = 120;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [7:0]           rx_byte = 8'h00;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [LAT_DEG_W-1:0] lat_degrees;
    logic [FRAC_W-1:0]    lat_fraction;
    logic [DEG_W-1:0]     lon_degrees;
    logic [FRAC_W-1:0]    lon_fraction;
    int                   errors;
    int                   pending;

    logic [7:0] sentence[$];
    int         sent_chars = 0;
    int         stall_cycles = 0;
    bit         calm = 1'b0;
    bit         gap_mode = 1'b0;
    bit         hold_request = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    nmea_gga_coordinate_extractor u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .lat_degrees  (lat_degrees),
        .lat_fraction (lat_fraction),
        .lon_degrees  (lon_degrees),
        .lon_fraction (lon_fraction)
    );

    gga_position_checker u_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .rx_byte           (rx_byte),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .lat_degrees       (lat_degrees),
        .lat_fraction      (lat_fraction),
        .lon_degrees       (lon_degrees),
        .lon_fraction      (lon_fraction),
        .errors            (errors),
        .pending           (pending)
    );

    function automatic logic [7:0] random_digit(input int hi);
        return 8'(CHAR_ZERO + $urandom_range(hi, 0));
    endfunction

    task automatic put_char(input logic [7:0] ch);
        sentence.push_back(ch);
    endtask

    task automatic put_text(input string text);
        int i;
        for (i = 0; i < text.len(); i++)
            sentence.push_back(text[i]);
    endtask

    task automatic put_digits(input int count);
        int i;
        for (i = 0; i < count; i++)
            sentence.push_back(random_digit(9));
    endtask

    // A coordinate with 'whole' characters before the dot; mostly well formed, sometimes
    // short, overlong or carrying stray characters.
    task automatic put_coordinate(input int whole);
        int         shape;
        int         width;
        int         i;
        logic [7:0] ch;
        shape = $urandom_range(0, 9);
        width = whole + 6;
        if (shape == 0)
            width = $urandom_range(0, whole + 5);
        else if (shape == 1)
            width = whole + 6 + $urandom_range(1, 4);
        for (i = 0; i < width; i++)
        begin
            if (i == whole)
                ch = ".";
            else if (i == whole - 2 && $urandom_range(0, 4) != 0)
                ch = random_digit(5);
            else
                ch = random_digit(9);
            if (shape == 2 && $urandom_range(0, 3) == 0)
                ch = 8'($urandom_range(0, 255));
            if (ch == CHAR_DOLLAR || ch == CHAR_COMMA)
                ch = "?";
            sentence.push_back(ch);
        end
    endtask

    task automatic put_gga_sentence();
        int tail;
        int i;
        put_char(CHAR_DOLLAR);
        put_text(($urandom_range(0, 3) == 0) ? "GNGGA," : "GPGGA,");
        if ($urandom_range(0, 3) != 0)
        begin
            put_digits(6);
            put_text(".");
            put_digits(2);
        end
        put_char(CHAR_COMMA);
        put_coordinate(4);
        put_text(($urandom_range(0, 1) == 0) ? ",N," : ",S,");
        put_coordinate(5);
        put_char(CHAR_COMMA);
        tail = $urandom_range(0, 6);
        for (i = 0; i < tail; i++)
        begin
            put_digits($urandom_range(0, 2));
            put_char(CHAR_COMMA);
        end
        put_text("*");
        put_digits(2);
        put_char(8'h0D);
        put_char(8'h0A);
    endtask

    // Another sentence type, whose fields may still spell the tag by accident.
    task automatic put_other_sentence();
        int fields;
        int count;
        int i;
        int j;
        put_char(CHAR_DOLLAR);
        put_text("GPRMC");
        fields = $urandom_range(2, 10);
        for (i = 0; i < fields; i++)
        begin
            put_char(CHAR_COMMA);
            count = $urandom_range(0, 5);
            for (j = 0; j < count; j++)
            begin
                case ($urandom_range(0, 3))
                    0: put_char("G");
                    1: put_char("A");
                    default: put_char(random_digit(9));
                endcase
            end
        end
    endtask

    task automatic put_noise();
        int count;
        int i;
        count = $urandom_range(1, 12);
        for (i = 0; i < count; i++)
            put_char(8'($urandom_range(0, 255)));
    endtask

    // Cuts the sentence short or drops a dollar sign into the middle of it.
    task automatic break_sentence();
        int spot;
        spot = $urandom_range(1, sentence.size() - 1);
        if ($urandom_range(0, 1) == 0)
        begin
            while (sentence.size() > spot)
                void'(sentence.pop_back());
        end
        else
            sentence.insert(spot, CHAR_DOLLAR);
    endtask

    // Called at a rising edge; returns at the edge where the beat is taken.
    task automatic send_char(input logic [7:0] ch);
        if (!calm && gap_mode && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= ch;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent_chars++;
    endtask

    task automatic send_sentence();
        while (sentence.size() > 0)
            send_char(sentence.pop_front());
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic directed_sentences();
        gap_mode = 1'b1;
        put_text("$GPGGA,123519,4807.03800,N,01131.00000,E,1,08,0.9,545.4,M,46.9,M,,*47");
        put_char(8'h0D);
        put_char(8'h0A);
        // Largest degrees and minutes, then commas beyond the counter's limit.
        put_text("$GPGGA,,9959.99999,N,99959.99999,E,,,,,");
        put_text("$GPGGA,,,,,");
        // Minutes of sixty and above saturate the fraction.
        put_text("$GNGGA,,0060.00000,S,00099.99999,W,");
        // Short fields are padded with zeros and excess characters are dropped.
        put_text("$GPGGA,,12,N,7,E,$GPGGA,,4807.0380123,N,01131.000009876,E,");
        // Characters other than digits, including the lowest and highest byte, count as zero.
        put_text("$GPGGA,,4A0");
        put_char(8'h00);
        put_text(".x3");
        put_char(8'hFF);
        put_text("999,N,1-2/3:45.67890,E,");
        put_text("$GPGGA,,4807.1$GPGGA,,1234.56789,N,12345.67890,E,");
        // Longitude is never closed, so this sentence gives nothing.
        put_text("$GPGGA,,4807.03800,N,01131.00000");
        // A dollar sign neither clears nor shifts the tag window.
        put_text("$xGG$A,,1111.11111,N,22222.22222,E,");
        put_text("$noiseGGA,,0000.00001,N,00000.00001,E,");
        send_sentence();
    endtask

    // Short sentences against a stalled output, so that the queue fills and input stalls.
    task automatic fill_under_hold();
        int i;
        gap_mode = 1'b0;
        hold_request = 1'b1;
        for (i = 0; i < FILL_COUNT; i++)
        begin
            put_text("$GPGGA,,");
            put_digits($urandom_range(0, 3));
            put_text(",,");
            put_digits($urandom_range(0, 3));
            put_char(CHAR_COMMA);
            send_sentence();
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin : receiver
        int quiet_left;
        quiet_left = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
                out_ready <= 1'b1;
            end
            else if (!calm && quiet_left == 0 && $urandom_range(0, 9) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
                out_ready <= 1'b1;
                quiet_left = $urandom_range(0, 150);
            end
            else
            begin
                out_ready <= 1'b1;
                if (quiet_left > 0)
                    quiet_left--;
            end
        end
    end

    initial
    begin
        int pick;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed_sentences();
        wait_drained();
        fill_under_hold();
        wait_drained();
        while (sent_chars < TOTAL_CHARS)
        begin
            calm = (sent_chars >= TOTAL_CHARS - CALM_CHARS);
            gap_mode = ($urandom_range(0, 2) != 0);
            pick = $urandom_range(0, 19);
            if (pick < 13)
                put_gga_sentence();
            else if (pick < 15)
                put_other_sentence();
            else if (pick < 17)
            begin
                put_gga_sentence();
                break_sentence();
            end
            else
                put_noise();
            send_sentence();
            if (!calm && $urandom_range(0, 29) == 0)
                wait_drained();
        end
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: files.f
rtl/gga_pkg.sv
rtl/gga_front.sv
rtl/gga_queue.sv
rtl/gga_cvt.sv
rtl/gga_back.sv
rtl/nmea_gga_coordinate_extractor.sv
tb/sv/gga_position_checker.sv
tb/sv/nmea_gga_coordinate_extractor_test.sv
